// File: hw/rtl/bfev_pkg.sv
// Shared types, constants and tables of the bond force / energy / virial block.
// No dependencies; every other file but bfev_mul refers to it by scoped names.
package bfev_pkg;

	// field widths
	localparam int ATOM_W = 16;
	localparam int POS_W  = 32;
	localparam int PAR_W  = 31;
	localparam int SUM_W  = 48;

	// stream payload widths, padded to whole bytes
	localparam int IN_BITS  = 2 * ATOM_W + 6 * POS_W + 2 * PAR_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * ATOM_W + 3 * POS_W + 2 * SUM_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// output word offsets
	localparam int OFS_FORCE  = 2 * ATOM_W;
	localparam int OFS_ENERGY = OFS_FORCE + 3 * POS_W;
	localparam int OFS_VIRIAL = OFS_ENERGY + SUM_W;

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KIND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd2;

	// potential kinds
	localparam logic KIND_HARMONIC = 1'b0;
	localparam logic KIND_MORSE    = 1'b1;

	// arithmetic constants
	localparam logic [63:0] CAP62      = 64'h4000_0000_0000_0000;
	localparam logic [31:0] LN2_Q32    = 32'd2977044472;
	localparam logic [63:0] EXP_BIG    = 64'd190530846208;   // 64 * ln2, Q32.32
	localparam logic [63:0] ONE_Q30    = 64'h0000_0000_4000_0000;
	localparam logic [36:0] RECIP_BASE = 37'h10_0000_0000;   // 2^36
	localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

	typedef struct packed {
		logic [ATOM_W-1:0] first_atom;
		logic [ATOM_W-1:0] second_atom;
		logic [POS_W-1:0]  first_x;
		logic [POS_W-1:0]  first_y;
		logic [POS_W-1:0]  first_z;
		logic [POS_W-1:0]  second_x;
		logic [POS_W-1:0]  second_y;
		logic [POS_W-1:0]  second_z;
		logic [PAR_W-1:0]  rest_length;
		logic [PAR_W-1:0]  spring_const;
		logic              last_bond;
	} bfev_item_t;

	typedef struct packed {
		logic [ATOM_W-1:0] out_first_atom;
		logic [ATOM_W-1:0] out_second_atom;
		logic [POS_W-1:0]  force_x;
		logic [POS_W-1:0]  force_y;
		logic [POS_W-1:0]  force_z;
		logic [SUM_W-1:0]  energy_total;
		logic [SUM_W-1:0]  virial_total;
		logic              zero_distance;
		logic              final_result;
	} bfev_res_t;

	typedef struct packed {
		logic             potential_kind;
		logic [PAR_W-1:0] morse_depth;
		logic [PAR_W-1:0] morse_width;
	} bfev_cfg_t;

	// floor(2^36 / n) for the Taylor divisors 1..12
	function automatic logic [36:0] recip(input logic [3:0] n);
		logic [36:0] v;
		case (n)
			4'd1:    v = RECIP_BASE;
			4'd2:    v = RECIP_BASE / 2;
			4'd3:    v = RECIP_BASE / 3;
			4'd4:    v = RECIP_BASE / 4;
			4'd5:    v = RECIP_BASE / 5;
			4'd6:    v = RECIP_BASE / 6;
			4'd7:    v = RECIP_BASE / 7;
			4'd8:    v = RECIP_BASE / 8;
			4'd9:    v = RECIP_BASE / 9;
			4'd10:   v = RECIP_BASE / 10;
			4'd11:   v = RECIP_BASE / 11;
			4'd12:   v = RECIP_BASE / 12;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/bfev_mul.sv
// Iterative 64x64 unsigned multiplier: one 32x32 partial product per cycle.
// Depends on nothing; used by bfev_core as the block's shared multiplier.
module bfev_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	// partial product select and alignment
	always_comb begin
		pa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		pb = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp = {32'd0, pa} * {32'd0, pb};
		case (cnt_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: hw/rtl/bfev_core.sv
// Sequencer and datapath of one bond: squares, square root, potential, sums, forces.
// Depends on bfev_pkg and bfev_mul; a shared compare/subtract serves root and divides.
module bfev_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bfev_pkg::bfev_item_t item,
	input  bfev_pkg::bfev_cfg_t  cfg,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_take,
	output bfev_pkg::bfev_res_t  res
);

	typedef enum logic [21:0] {
		S_IDLE = 22'h000001,
		S_SQ   = 22'h000002,
		S_SQRT = 22'h000004,
		S_HG   = 22'h000008,
		S_HE   = 22'h000010,
		S_MP   = 22'h000020,
		S_XDIV = 22'h000040,
		S_TMUL = 22'h000080,
		S_TREC = 22'h000100,
		S_TFIX = 22'h000200,
		S_XFIN = 22'h000400,
		S_MM   = 22'h000800,
		S_MB   = 22'h001000,
		S_MG1  = 22'h002000,
		S_MG2  = 22'h004000,
		S_ME1  = 22'h008000,
		S_ME2  = 22'h010000,
		S_VIR  = 22'h020000,
		S_SUMS = 22'h040000,
		S_FMUL = 22'h080000,
		S_FDIV = 22'h100000,
		S_DONE = 22'h200000
	} state_t;

	state_t state_q;

	// min(v, 2^62)
	function automatic logic [63:0] cap62(input logic [127:0] v);
		return (v > {64'd0, bfev_pkg::CAP62}) ? bfev_pkg::CAP62 : v[63:0];
	endfunction

	// clamp a 66-bit signed sum to 48 bits
	function automatic logic [47:0] sat48(input logic [65:0] x);
		logic [47:0] v;
		if (x[65:47] != {19{x[65]}})
			v = x[65] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		else
			v = x[47:0];
		return v;
	endfunction

	bfev_pkg::bfev_item_t item_q;
	logic [2:0][31:0] dmag_q, dmag_in;
	logic [2:0]       dneg_q, dneg_in;
	logic [2:0][31:0] frc_q;
	logic [1:0]       idx_q;
	logic [65:0]      sq_q;
	logic [35:0]      rem_q;
	logic [32:0]      root_q;
	logic [5:0]       cnt_q;
	logic [31:0]      lo_q, qd_q;
	logic             sat_q, zero_q, drneg_q, gneg_q, expneg_q;
	logic [32:0]      drmag_q;
	logic [63:0]      gmag_q, emag_q, vmag_q, e_q, mm_q, bb_q, dr2_q;
	logic [39:0]      rr_q;
	logic [5:0]       qx_q;
	logic [7:0]       k_q;
	logic [31:0]      f_q, x_q, qe_q;
	logic [32:0]      term_q;
	logic [33:0]      esum_q;
	logic [3:0]       ti_q;
	logic [47:0]      energy_q, virial_q, res_e_q, res_v_q;
	logic             mul_wait_q;

	logic         mul_start, mul_done, is_mul;
	logic [63:0]  mul_a, mul_b;
	logic [127:0] mp;

	bfev_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mp)
	);

	// coordinate differences of the incoming bond
	always_comb begin
		logic [2:0][31:0] pa, pb;
		logic [32:0] dk;
		pa = {item.first_z, item.first_y, item.first_x};
		pb = {item.second_z, item.second_y, item.second_x};
		for (int k = 0; k < 3; k++) begin
			dk = {pa[k][31], pa[k]} - {pb[k][31], pb[k]};
			dneg_in[k] = dk[32];
			dmag_in[k] = dk[32] ? 32'(-dk) : dk[31:0];
		end
	end

	// multiplier operand select
	always_comb begin
		is_mul = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = {32'd0, dmag_q[idx_q]};
				mul_b = {32'd0, dmag_q[idx_q]};
			end
			S_HG: begin
				mul_a = {33'd0, item_q.spring_const};
				mul_b = {31'd0, drmag_q};
			end
			S_HE: begin
				mul_a = gmag_q;
				mul_b = {31'd0, drmag_q};
			end
			S_MP: begin
				mul_a = {33'd0, cfg.morse_width};
				mul_b = {31'd0, drmag_q};
			end
			S_TMUL: begin
				mul_a = {31'd0, term_q};
				mul_b = {32'd0, f_q};
			end
			S_TREC: begin
				mul_a = {32'd0, x_q};
				mul_b = {27'd0, bfev_pkg::recip(ti_q)};
			end
			S_MB: begin
				mul_a = mm_q;
				mul_b = e_q;
			end
			S_MG1: begin
				mul_a = {33'd0, cfg.morse_depth};
				mul_b = {33'd0, cfg.morse_width};
			end
			S_MG2: begin
				mul_a = dr2_q;
				mul_b = bb_q;
			end
			S_ME1: begin
				mul_a = mm_q;
				mul_b = mm_q;
			end
			S_ME2: begin
				mul_a = {33'd0, cfg.morse_depth};
				mul_b = bb_q;
			end
			S_VIR: begin
				mul_a = gmag_q;
				mul_b = {31'd0, root_q};
			end
			S_FMUL: begin
				mul_a = gmag_q;
				mul_b = {32'd0, dmag_q[idx_q]};
			end
			default: is_mul = 1'b0;
		endcase
	end

	assign mul_start = is_mul && !mul_wait_q;

	// shared compare/subtract: root digits, range reduction, force divide
	logic [35:0] rem_sq;
	logic [33:0] rem_dv;
	logic [39:0] sub_a, sub_b;
	logic [40:0] diff;
	logic        ge;
	logic [32:0] root_nx;
	logic [34:0] dr_w;

	always_comb begin
		rem_sq = {rem_q[33:0], sq_q[65:64]};
		rem_dv = {rem_q[32:0], lo_q[31]};
		unique case (state_q)
			S_SQRT: begin
				sub_a = {4'd0, rem_sq};
				sub_b = {5'd0, root_q, 2'b01};
			end
			S_XDIV: begin
				sub_a = rr_q;
				sub_b = {8'd0, bfev_pkg::LN2_Q32} << cnt_q[2:0];
			end
			S_FDIV: begin
				sub_a = {6'd0, rem_dv};
				sub_b = {7'd0, root_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
		diff    = {1'b0, sub_a} - {1'b0, sub_b};
		ge      = ~diff[40];
		root_nx = {root_q[31:0], ge};
		dr_w    = {2'b00, root_nx} - {4'd0, item_q.rest_length};
	end

	// end of range reduction: exponent k and fraction f
	logic [39:0] rr_nx;
	logic [5:0]  q_nx;
	logic [7:0]  k_nx;
	logic [31:0] f_nx;

	always_comb begin
		rr_nx = ge ? diff[39:0] : rr_q;
		q_nx  = {qx_q[4:0], ge};
		if (!expneg_q) begin
			k_nx = {2'b00, q_nx};
			f_nx = rr_nx[31:0];
		end else if (rr_nx == 40'd0) begin
			k_nx = -{2'b00, q_nx};
			f_nx = '0;
		end else begin
			k_nx = ~{2'b00, q_nx};
			f_nx = bfev_pkg::LN2_Q32 - rr_nx[31:0];
		end
	end

	// Taylor term correction after reciprocal multiply
	logic [35:0] prodq, remx;
	logic [31:0] qf;

	always_comb begin
		prodq = {4'd0, qe_q} * {32'd0, ti_q};
		remx  = {4'd0, x_q} - prodq;
		qf    = (remx >= {32'd0, ti_q}) ? qe_q + 32'd1 : qe_q;
	end

	// scale the series by 2^(k-2) into Q34.30
	logic [8:0]  n9, nn9;
	logic [63:0] e_fin;

	always_comb begin
		n9  = {k_q[7], k_q} - 9'd2;
		nn9 = -n9;
		if (!n9[8]) begin
			if (k_q[6:5] != 2'b00)
				e_fin = bfev_pkg::CAP62;
			else
				e_fin = {30'd0, esum_q} << n9[4:0];
		end else if (nn9[8:6] != 3'd0) begin
			e_fin = '0;
		end else begin
			e_fin = {30'd0, esum_q} >> nn9[5:0];
		end
	end

	// running sums with this bond
	logic [65:0] es, vs;
	logic [47:0] e_new, v_new;

	always_comb begin
		es = {{18{energy_q[47]}}, energy_q} + {2'b00, emag_q};
		if (gneg_q)
			vs = {{18{virial_q[47]}}, virial_q} + {2'b00, vmag_q};
		else
			vs = {{18{virial_q[47]}}, virial_q} - {2'b00, vmag_q};
		e_new = sat48(es);
		v_new = sat48(vs);
	end

	// force component from the finished quotient
	logic [31:0] q_fin, f_out;
	logic [32:0] fmag;
	logic        fneg;

	always_comb begin
		q_fin = {qd_q[30:0], ge};
		fmag  = sat_q ? 33'h1_0000_0000 : {1'b0, q_fin};
		fneg  = !(gneg_q ^ dneg_q[idx_q]);
		if (fmag == 33'd0)
			f_out = '0;
		else if (fneg)
			f_out = (fmag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-fmag);
		else
			f_out = (fmag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : fmag[31:0];
	end

	// sequencer, multiplier handshake and accumulated sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mul_wait_q <= 1'b0;
			energy_q   <= '0;
			virial_q   <= '0;
		end else begin
			if (mul_start)
				mul_wait_q <= 1'b1;
			else if (mul_done)
				mul_wait_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_SQ;
				S_SQ:   if (mul_done && idx_q == 2'd2) state_q <= S_SQRT;
				S_SQRT: begin
					if (cnt_q == 6'd0)
						state_q <= (cfg.potential_kind == bfev_pkg::KIND_MORSE) ? S_MP : S_HG;
				end
				S_HG:   if (mul_done) state_q <= S_HE;
				S_HE:   if (mul_done) state_q <= S_VIR;
				S_MP: begin
					if (mul_done)
						state_q <= (mp[63:0] >= bfev_pkg::EXP_BIG) ? S_MM : S_XDIV;
				end
				S_XDIV: if (cnt_q == 6'd0) state_q <= S_TMUL;
				S_TMUL: if (mul_done) state_q <= S_TREC;
				S_TREC: if (mul_done) state_q <= S_TFIX;
				S_TFIX: state_q <= (ti_q == bfev_pkg::TAYLOR_TERMS) ? S_XFIN : S_TMUL;
				S_XFIN: state_q <= S_MM;
				S_MM:   state_q <= S_MB;
				S_MB:   if (mul_done) state_q <= S_MG1;
				S_MG1:  if (mul_done) state_q <= S_MG2;
				S_MG2:  if (mul_done) state_q <= S_ME1;
				S_ME1:  if (mul_done) state_q <= S_ME2;
				S_ME2:  if (mul_done) state_q <= S_VIR;
				S_VIR:  if (mul_done) state_q <= S_SUMS;
				S_SUMS: begin
					state_q  <= zero_q ? S_DONE : S_FMUL;
					energy_q <= item_q.last_bond ? '0 : e_new;
					virial_q <= item_q.last_bond ? '0 : v_new;
				end
				S_FMUL: if (mul_done) state_q <= S_FDIV;
				S_FDIV: begin
					if (cnt_q == 6'd0)
						state_q <= (idx_q == 2'd2) ? S_DONE : S_FMUL;
				end
				S_DONE: if (res_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					item_q <= item;
					dmag_q <= dmag_in;
					dneg_q <= dneg_in;
					sq_q   <= '0;
					idx_q  <= '0;
				end
			end
			S_SQ: begin
				if (mul_done) begin
					sq_q  <= sq_q + mp[65:0];
					idx_q <= idx_q + 2'd1;
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= 6'd32;
				end
			end
			S_SQRT: begin
				rem_q  <= ge ? diff[35:0] : rem_sq;
				root_q <= root_nx;
				sq_q   <= {sq_q[63:0], 2'b00};
				cnt_q  <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					zero_q  <= (root_nx == 33'd0);
					drneg_q <= dr_w[34];
					drmag_q <= dr_w[34] ? 33'(-dr_w) : dr_w[32:0];
				end
			end
			S_HG: begin
				if (mul_done) begin
					gmag_q <= cap62(mp >> 16);
					gneg_q <= drneg_q;
				end
			end
			S_HE: if (mul_done) emag_q <= cap62(mp >> 17);
			S_MP: begin
				if (mul_done) begin
					expneg_q <= !drneg_q;
					rr_q     <= mp[39:0];
					qx_q     <= '0;
					cnt_q    <= 6'd5;
					e_q      <= drneg_q ? bfev_pkg::CAP62 : 64'd0;
				end
			end
			S_XDIV: begin
				rr_q  <= rr_nx;
				qx_q  <= q_nx;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					k_q    <= k_nx;
					f_q    <= f_nx;
					term_q <= 33'h1_0000_0000;
					esum_q <= 34'h1_0000_0000;
					ti_q   <= 4'd1;
				end
			end
			S_TMUL: if (mul_done) x_q <= mp[63:32];
			S_TREC: if (mul_done) qe_q <= mp[67:36];
			S_TFIX: begin
				term_q <= {1'b0, qf};
				esum_q <= esum_q + {2'b00, qf};
				ti_q   <= ti_q + 4'd1;
			end
			S_XFIN: e_q <= e_fin;
			S_MM: begin
				gneg_q <= (e_q > bfev_pkg::ONE_Q30);
				mm_q   <= (e_q > bfev_pkg::ONE_Q30) ? e_q - bfev_pkg::ONE_Q30
				                                    : bfev_pkg::ONE_Q30 - e_q;
			end
			S_MB:  if (mul_done) bb_q <= cap62(mp >> 30);
			S_MG1: if (mul_done) dr2_q <= {mp[62:0], 1'b0};
			S_MG2: if (mul_done) gmag_q <= cap62(mp >> 46);
			S_ME1: if (mul_done) bb_q <= cap62(mp >> 30);
			S_ME2: if (mul_done) emag_q <= cap62(mp >> 30);
			S_VIR: if (mul_done) vmag_q <= cap62(mp >> 16);
			S_SUMS: begin
				res_e_q <= e_new;
				res_v_q <= v_new;
				idx_q   <= '0;
				frc_q   <= '0;
			end
			S_FMUL: begin
				if (mul_done) begin
					sat_q <= (|mp[127:65]) || (mp[64:32] >= root_q);
					rem_q <= {3'd0, mp[64:32]};
					lo_q  <= mp[31:0];
					qd_q  <= '0;
					cnt_q <= 6'd31;
				end
			end
			S_FDIV: begin
				rem_q <= ge ? diff[35:0] : {2'b00, rem_dv};
				lo_q  <= {lo_q[30:0], 1'b0};
				qd_q  <= q_fin;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					frc_q[idx_q] <= f_out;
					idx_q        <= idx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// result word
	always_comb begin
		res.out_first_atom  = item_q.first_atom;
		res.out_second_atom = item_q.second_atom;
		res.force_x         = frc_q[0];
		res.force_y         = frc_q[1];
		res.force_z         = frc_q[2];
		res.energy_total    = res_e_q;
		res.virial_total    = res_v_q;
		res.zero_distance   = zero_q;
		res.final_result    = item_q.last_bond;
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

endmodule

// File: hw/rtl/bond_force_energy_virial_top.sv
// Top level of the bond force / energy / virial block: ports, registers, output stage.
// Depends on bfev_pkg and bfev_core.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata bond word, s_tlast last bond
//  m_*     | out       | m_tvalid/m_tready  | m_tdata result, m_tuser zero flag, m_tlast
//  cfg_*   | in        | cfg_we             | cfg_index, cfg_data
//
// One bond at a time through a sequencer over an iterative 64x64 multiplier
// and one shared compare/subtract; a Morse bond sums 12 Taylor terms for its
// exponential unless the argument is large, and coincident atoms skip the force
// divide. The root takes 33 steps and each force divide 32 steps.
// arst_n clears the sequencer, the sums, the configuration registers and the output valid flag.
// A finished result waits in the output register; the next bond is taken meanwhile.
module bond_force_energy_virial_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// first_atom, second_atom, first_x, first_y, first_z, second_x, second_y,
	// second_z, rest_length, spring_const, zero fill
	input  logic [bfev_pkg::IN_W-1:0]          s_tdata,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_first_atom, out_second_atom, force_x, force_y, force_z,
	// energy_total, virial_total
	output logic [bfev_pkg::OUT_W-1:0]         m_tdata,
	// zero_distance
	output logic [0:0]                         m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [bfev_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfev_pkg::PAR_W-1:0]         cfg_data
);

	bfev_pkg::bfev_cfg_t  cfg_q;
	bfev_pkg::bfev_item_t item;
	bfev_pkg::bfev_res_t  res, out_q;
	logic                 core_idle, res_valid, res_take, m_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfev_pkg::CFG_KIND:  cfg_q.potential_kind <= cfg_data[0];
				bfev_pkg::CFG_DEPTH: cfg_q.morse_depth    <= cfg_data;
				bfev_pkg::CFG_WIDTH: cfg_q.morse_width    <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack input word
	always_comb begin
		{item.spring_const, item.rest_length, item.second_z, item.second_y,
		 item.second_x, item.first_z, item.first_y, item.first_x,
		 item.second_atom, item.first_atom} = s_tdata[bfev_pkg::IN_BITS-1:0];
		item.last_bond = s_tlast;
	end

	bfev_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && s_tready),
		.item      (item),
		.cfg       (cfg_q),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign s_tready = core_idle;
	assign res_take = res_valid && (!m_valid_q || m_tready);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (res_take)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_take)
			out_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = bfev_pkg::OUT_W'({out_q.virial_total, out_q.energy_total,
		out_q.force_z, out_q.force_y, out_q.force_x,
		out_q.out_second_atom, out_q.out_first_atom});
	assign m_tuser  = out_q.zero_distance;
	assign m_tlast  = out_q.final_result;

endmodule

// File: hw/rtl/bfev_checker.sv
// Port-level checks on the bond force / energy / virial block, bound to its top.
// Depends on bfev_pkg and bond_force_energy_virial_top.
module bfev_port_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [bfev_pkg::OUT_W-1:0] m_tdata,
	input logic [0:0]                 m_tuser
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	// a taken bond keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a bond was taken");

	// coincident atoms give zero force
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[bfev_pkg::OFS_ENERGY-1:bfev_pkg::OFS_FORCE] == '0)
		else $error("force nonzero with zero distance");

	// energy terms are never negative, so the sum is not
	a_energy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[bfev_pkg::OFS_VIRIAL-1])
		else $error("energy sum negative");

endmodule

bind bond_force_energy_virial_top bfev_port_checker u_bfev_checker (.*);
